### hdl/ceg_pkg.sv
// Package for the cosine envelope gain block: ramp codes, register
// indexes, the control struct and the cosine table entry function.
// No dependencies.
`default_nettype none
package ceg_pkg;

  localparam logic [1:0] RAMP_NONE   = 2'd0;
  localparam logic [1:0] RAMP_ATTACK = 2'd1;
  localparam logic [1:0] RAMP_DECAY  = 2'd2;

  localparam logic [1:0] REG_ATTACK_TIME     = 2'd0;
  localparam logic [1:0] REG_DECAY_START     = 2'd1;
  localparam logic [1:0] REG_ENVELOPE_LENGTH = 2'd2;

  // Reciprocals for the Taylor term divisors, ceil(2^48 / d); exact for terms up to 2^30
  localparam int RECIP_SHIFT = 48;
  localparam longint unsigned RECIP_2   = ((64'd1 << 48) + 64'd1) / 64'd2;
  localparam longint unsigned RECIP_12  = ((64'd1 << 48) + 64'd11) / 64'd12;
  localparam longint unsigned RECIP_30  = ((64'd1 << 48) + 64'd29) / 64'd30;
  localparam longint unsigned RECIP_56  = ((64'd1 << 48) + 64'd55) / 64'd56;
  localparam longint unsigned RECIP_90  = ((64'd1 << 48) + 64'd89) / 64'd90;
  localparam longint unsigned RECIP_132 = ((64'd1 << 48) + 64'd131) / 64'd132;

  // Per-item control carried from classification to the output
  typedef struct packed {
    logic [1:0] ramp;
    logic       fault;
  } ceg_ctrl_t;

  // Cosine table entry: cos(i / 2^ctb) in Q1.16, Taylor series to x^12 in Q2.30
  function automatic logic [16:0] cos_entry(input int unsigned i, input int unsigned ctb);
    longint unsigned x;
    longint unsigned term;
    longint unsigned rc;
    logic [127:0]    scaled;
    longint          sum;
    longint unsigned res;
    x    = longint'(i) << (30 - ctb);
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (k)
        1: rc = RECIP_2;
        2: rc = RECIP_12;
        3: rc = RECIP_30;
        4: rc = RECIP_56;
        5: rc = RECIP_90;
        default: rc = RECIP_132;
      endcase
      // Divide the term by the factorial step through its reciprocal
      scaled = 128'(term) * 128'(rc);
      term   = 64'(scaled >> RECIP_SHIFT);
      if (k[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    res = (longint'(sum) + 64'd8192) >> 14;
    if (res > 64'd65536) res = 64'd65536;
    return res[16:0];
  endfunction

endpackage
`default_nettype wire

### hdl/ceg_if.sv
// Stream interfaces for the cosine envelope gain block: input beats
// (time, volume) and result beats (volume, ramp, fault). No dependencies.
`default_nettype none
interface ceg_in_if #(parameter int TIME_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] play_time;
  logic [15:0]          volume_in;
  modport source (output valid, play_time, volume_in, input ready);
  modport sink (input valid, play_time, volume_in, output ready);
endinterface

interface ceg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] volume_out;
  logic [1:0]  ramp_phase;
  logic        span_fault;
  modport source (output valid, volume_out, ramp_phase, span_fault, input ready);
  modport sink (input valid, volume_out, ramp_phase, span_fault, output ready);
endinterface
`default_nettype wire

### hdl/ceg_front.sv
// Front end: APB register file and classification of input beats into
// attack, decay or pass. Depends on ceg_pkg and ceg_in_if.
`default_nettype none
module ceg_front
  import ceg_pkg::*;
#(
  parameter int TIME_BITS = 24,
  parameter int QW = 2 * TIME_BITS + 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  ceg_in_if.sink                    in_ch,
  output logic                      q_valid,
  output logic      [QW-1:0]        q_data,
  input  wire logic                 q_ready
);

  logic [TIME_BITS-1:0] attack_time;
  logic [TIME_BITS-1:0] decay_start;
  logic [TIME_BITS-1:0] envelope_length;
  logic                 wr;
  logic [TIME_BITS-1:0] num;
  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS-1:0] t;
  ceg_ctrl_t            ctrl;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time     <= '0;
      decay_start     <= '0;
      envelope_length <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_ATTACK_TIME:     attack_time     <= pwdata[TIME_BITS-1:0];
        REG_DECAY_START:     decay_start     <= pwdata[TIME_BITS-1:0];
        REG_ENVELOPE_LENGTH: envelope_length <= pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_ATTACK_TIME:     prdata = 32'(attack_time);
      REG_DECAY_START:     prdata = 32'(decay_start);
      REG_ENVELOPE_LENGTH: prdata = 32'(envelope_length);
      default:             prdata = '0;
    endcase
  end

  // Classify the beat and form the division operands
  assign t = in_ch.play_time;
  always_comb begin
    ctrl.ramp  = RAMP_NONE;
    ctrl.fault = 1'b0;
    num        = t;
    den        = attack_time;
    if (attack_time != '0 && t < attack_time) begin
      ctrl.ramp = RAMP_ATTACK;
    end else if (decay_start != '0 && t > decay_start) begin
      ctrl.ramp  = RAMP_DECAY;
      ctrl.fault = envelope_length <= decay_start;
      num        = t - decay_start;
      den        = envelope_length - decay_start;
    end
  end

  assign q_valid     = in_ch.valid;
  assign in_ch.ready = q_ready;
  assign q_data      = {num, den, in_ch.volume_in, ctrl};

endmodule
`default_nettype wire

### hdl/ceg_queue.sv
// Two-entry queue between the front end and the gain pipeline.
// No dependencies.
`default_nettype none
module ceg_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic      [W-1:0] out_data
);

  logic [W-1:0] mem [0:1];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         push;
  logic         pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Store beat
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hdl/ceg_back.sv
// Gain pipeline: restoring divider, phase folding, cosine table and volume
// multiply, all stalled together by the output. Depends on ceg_pkg, ceg_out_if.
`default_nettype none
module ceg_back
  import ceg_pkg::*;
#(
  parameter int TIME_BITS       = 24,
  parameter int PHASE_FRAC_BITS = 14,
  parameter int COS_TABLE_BITS  = 10,
  parameter int QW              = 2 * TIME_BITS + 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire logic [QW-1:0] q_data,
  ceg_out_if.source          out_ch
);

  localparam int TB = TIME_BITS;
  localparam int F  = PHASE_FRAC_BITS;
  localparam int C  = COS_TABLE_BITS;
  localparam int RW = TB + 2;
  localparam int NS = F + 2;
  localparam int NE = (1 << C) + 1;
  localparam logic [F+1:0] PHASE_ONE = (F+2)'(1) << F;
  localparam logic [F+1:0] PHASE_MAX = (F+2)'(1) << (F + 1);

  logic [TB-1:0] num;
  logic [TB-1:0] den;
  logic [15:0]   vol;
  ceg_ctrl_t     ctrl;
  logic          en;

  // Divider stage registers
  logic [NS:0]   sv;
  logic [RW-1:0] sr   [0:NS];
  logic [RW-1:0] sd   [0:NS];
  logic [F+1:0]  sq   [0:NS];
  logic          so   [0:NS];
  logic [15:0]   svol [0:NS];
  ceg_ctrl_t     sc   [0:NS];

  logic [F+1:0]   phase;
  logic [F:0]     arg;
  logic [F+C:0]   idx_wide;
  logic [C:0]     idx;

  logic           av;
  logic [C:0]     aidx;
  logic [15:0]    avol;
  ceg_ctrl_t      actrl;

  logic [16:0]    rom [0:NE-1];
  logic           bv;
  logic [16:0]    bc;
  logic [15:0]    bvol;
  ceg_ctrl_t      bctrl;

  logic [16:0]    gain;
  logic [32:0]    prod;
  logic [32:0]    rnd;

  logic           cv;
  logic [15:0]    cvol;
  ceg_ctrl_t      cctrl;

  assign {num, den, vol, ctrl} = q_data;
  assign en      = !cv || out_ch.ready;
  assign q_ready = en;

  // Load the first divider stage
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= q_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0]   <= {2'b00, num};
      sd[0]   <= {den, 2'b00};
      sq[0]   <= '0;
      so[0]   <= {2'b00, num} >= {den, 2'b00};
      svol[0] <= vol;
      sc[0]   <= ctrl;
    end
  end

  // One quotient bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_div
    logic [RW:0] r2;
    logic        ge;
    logic [RW:0] diff;
    assign r2   = {sr[s], 1'b0};
    assign ge   = r2 >= {1'b0, sd[s]};
    assign diff = r2 - {1'b0, sd[s]};
    always_ff @(posedge clk) begin
      if (rst) sv[s+1] <= 1'b0;
      else if (en) sv[s+1] <= sv[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr[s+1]   <= ge ? diff[RW-1:0] : r2[RW-1:0];
        sd[s+1]   <= sd[s];
        sq[s+1]   <= {sq[s][F:0], ge};
        so[s+1]   <= so[s];
        svol[s+1] <= svol[s];
        sc[s+1]   <= sc[s];
      end
    end
  end

  // Saturate phase, fold decay argument, form table index
  always_comb begin
    if (so[NS] || sc[NS].fault || sq[NS] > PHASE_MAX) phase = PHASE_MAX;
    else phase = sq[NS];
    if (sc[NS].ramp == RAMP_ATTACK) arg = phase[F:0];
    else if (phase <= PHASE_ONE) arg = (F+1)'(PHASE_ONE - phase);
    else arg = (F+1)'(phase - PHASE_ONE);
    idx_wide = {arg, {C{1'b0}}};
    idx      = (C+1)'(idx_wide >> F);
  end

  always_ff @(posedge clk) begin
    if (rst) av <= 1'b0;
    else if (en) av <= sv[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      aidx  <= idx;
      avol  <= svol[NS];
      actrl <= sc[NS];
    end
  end

  // Cosine table
  for (genvar i = 0; i < NE; i++) begin : g_rom
    localparam logic [16:0] ENTRY = cos_entry(i, C);
    assign rom[i] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (rst) bv <= 1'b0;
    else if (en) bv <= av;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bc    <= rom[aidx];
      bvol  <= avol;
      bctrl <= actrl;
    end
  end

  // Scale volume by the gain, round half up; pass it unchanged outside a ramp
  assign gain = 17'h10000 - bc;
  assign prod = 33'(bvol) * 33'(gain);
  assign rnd  = prod + 33'd32768;

  always_ff @(posedge clk) begin
    if (rst) cv <= 1'b0;
    else if (en) cv <= bv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cvol  <= (bctrl.ramp == RAMP_NONE) ? bvol : rnd[31:16];
      cctrl <= bctrl;
    end
  end

  assign out_ch.valid      = cv;
  assign out_ch.volume_out = cvol;
  assign out_ch.ramp_phase = cctrl.ramp;
  assign out_ch.span_fault = cctrl.fault;

`ifndef SYNTHESIS
  a_fault_decay: assert property (@(posedge clk) disable iff (rst)
    cv && cctrl.fault |-> cctrl.ramp == RAMP_DECAY)
    else $error("span fault outside decay ramp");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    sv[NS] |-> idx <= (C+1)'(1 << C))
    else $error("cosine index out of range");
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    sv[NS] && so[NS] |-> phase == PHASE_MAX)
    else $error("overflowed quotient not saturated");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    cv && !out_ch.ready |=> cv && $stable(cvol))
    else $error("result lost during stall");
`endif

endmodule
`default_nettype wire

### hdl/cosine_envelope_gain_core.sv
// Top level of the cosine envelope gain block: APB registers, front end,
// queue and gain pipeline. Depends on ceg_pkg, ceg_if, ceg_front, ceg_queue, ceg_back.
//
// Usage: program attack_time (0x0), decay_start (0x4) and envelope_length
// (0x8) over APB while the block is idle. Send beats of play_time and
// volume_in on in_ch; each produces one beat of volume_out, ramp_phase and
// span_fault on out_ch, in order.
// Throughput: one beat per cycle while out_ch does not stall. Each beat
// passes through the queue, operand load, one restoring divider stage per
// quotient bit, phase fold, table read and multiply.
// The divider pipeline depth sets the latency.
// Reset (synchronous, rst high) clears the registers to zero and empties the
// queue and pipeline. When the receiver stalls, the whole pipeline holds and
// the two-entry queue keeps taking beats until full, then drops in_ch.ready.
`default_nettype none
module cosine_envelope_gain_core
  import ceg_pkg::*;
#(
  parameter int TIME_BITS       = 24,
  parameter int PHASE_FRAC_BITS = 14,
  parameter int COS_TABLE_BITS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  ceg_in_if.sink           in_ch,
  ceg_out_if.source        out_ch
);

  localparam int QW = 2 * TIME_BITS + 16 + $bits(ceg_ctrl_t);

  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  // Accept and classify
  ceg_front #(.TIME_BITS(TIME_BITS), .QW(QW)) u_front (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch),
    .q_valid(fq_valid), .q_data(fq_data), .q_ready(fq_ready)
  );

  // Decouple front and back
  ceg_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
  );

  // Divide, look up and scale
  ceg_back #(
    .TIME_BITS(TIME_BITS), .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .COS_TABLE_BITS(COS_TABLE_BITS), .QW(QW)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire

### tb/tb_cosine_envelope_gain_core.sv
// Testbench for cosine_envelope_gain_core: directed table, then random beats
// under several register settings, checked against an in-bench envelope predictor.
// Depends on ceg_pkg, ceg_if and the block's RTL.
`default_nettype none
module tb_cosine_envelope_gain_core;
  import ceg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_SETTINGS = 8;
  localparam int RANDOM_PER_SETTING = 140;

  typedef struct {
    logic [15:0] volume;
    logic [1:0]  ramp;
    logic        fault;
  } gain_result_t;

  typedef struct {
    int          setting;
    logic [23:0] play_time;
    logic [15:0] volume;
    bit          typed;
    logic [15:0] typed_volume;
    logic [1:0]  typed_ramp;
    logic        typed_fault;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ceg_in_if #(.TIME_BITS(24)) in_ch ();
  ceg_out_if out_ch ();

  cosine_envelope_gain_core dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Register settings: attack, decay start, envelope length
  logic [23:0] set_attack [NUM_SETTINGS] = '{24'd0, 24'd1000, 24'd100, 24'hFFFFFF,
                                              24'd1, 24'd0, 24'd4096, 24'd20000};
  logic [23:0] set_decay  [NUM_SETTINGS] = '{24'd0, 24'd5000, 24'd200, 24'd0,
                                              24'd1, 24'hFFFFFF, 24'd8192, 24'd40000};
  logic [23:0] set_length [NUM_SETTINGS] = '{24'd0, 24'd9000, 24'd150, 24'd0,
                                              24'hFFFFFF, 24'hFFFFFF, 24'd8193, 24'd60000};

  stim_row_t directed [] = '{
    '{0, 24'd0,       16'h0000, 1, 16'h0000, RAMP_NONE, 1'b0},
    '{0, 24'hFFFFFF,  16'hFFFF, 1, 16'hFFFF, RAMP_NONE, 1'b0},
    '{0, 24'd123,     16'h1000, 1, 16'h1000, RAMP_NONE, 1'b0},
    '{0, 24'hAAAAAA,  16'h5555, 1, 16'h5555, RAMP_NONE, 1'b0},
    '{0, 24'h555555,  16'hAAAA, 1, 16'hAAAA, RAMP_NONE, 1'b0},
    '{1, 24'd0,       16'hFFFF, 1, 16'h0000, RAMP_ATTACK, 1'b0},
    '{1, 24'd500,     16'h1000, 0, '0, '0, '0},
    '{1, 24'd999,     16'hFFFF, 0, '0, '0, '0},
    '{1, 24'd1000,    16'h1234, 1, 16'h1234, RAMP_NONE, 1'b0},
    '{1, 24'd5000,    16'h4321, 1, 16'h4321, RAMP_NONE, 1'b0},
    '{1, 24'd5001,    16'hFFFF, 0, '0, '0, '0},
    '{1, 24'd7000,    16'h1000, 0, '0, '0, '0},
    '{1, 24'd9000,    16'hFFFF, 1, 16'h0000, RAMP_DECAY, 1'b0},
    '{1, 24'd13000,   16'hFFFF, 0, '0, '0, '0},
    '{1, 24'hFFFFFF,  16'hFFFF, 0, '0, '0, '0},
    '{2, 24'd50,      16'hFFFF, 0, '0, '0, '0},
    '{2, 24'd150,     16'h2000, 1, 16'h2000, RAMP_NONE, 1'b0},
    '{2, 24'd200,     16'h2000, 1, 16'h2000, RAMP_NONE, 1'b0},
    '{2, 24'd201,     16'hFFFF, 0, '0, '0, '0},
    '{2, 24'hFFFFFF,  16'h0000, 1, 16'h0000, RAMP_DECAY, 1'b1},
    '{2, 24'd5000,    16'h8000, 0, '0, '0, '0}
  };

  logic [16:0]  cos_table [1025];
  logic [23:0]  cur_attack, cur_decay, cur_length;
  gain_result_t pending_gain [$];
  int           mismatch_count = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           cycle_count = 0;
  bit           quiet = 0;
  bit           pressure_req = 0;

  // Taylor cosine in Q2.30, rounded to Q1.16
  function automatic logic [16:0] taylor_cos(input int unsigned idx);
    longint unsigned x, term, r;
    longint          acc;
    x = longint'(idx) << 20;
    term = 64'd1 << 30;
    acc = 64'sd1 << 30;
    for (int k = 1; k <= 6; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = ($unsigned(acc) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  function automatic logic [15:0] scaled_volume(input logic [15:0] vol,
                                                input longint unsigned arg);
    longint unsigned idx, gain, prod;
    idx = (arg << 10) >> 14;
    if (idx > 1024) idx = 1024;
    gain = 65536 - cos_table[idx];
    prod = (longint'(vol) * gain + 32768) >> 16;
    return prod[15:0];
  endfunction

  function automatic gain_result_t predict_gain(input logic [23:0] t,
                                                input logic [15:0] vol);
    gain_result_t r;
    longint unsigned phase, arg;
    r.volume = vol;
    r.ramp = RAMP_NONE;
    r.fault = 1'b0;
    if (cur_attack != 0 && t < cur_attack) begin
      phase = (longint'(t) << 14) / cur_attack;
      if (phase > 32768) phase = 32768;
      r.volume = scaled_volume(vol, phase);
      r.ramp = RAMP_ATTACK;
    end else if (cur_decay != 0 && t > cur_decay) begin
      if (cur_length <= cur_decay) begin
        r.fault = 1'b1;
        phase = 32768;
      end else begin
        phase = (longint'(t - cur_decay) << 14) / (cur_length - cur_decay);
        if (phase > 32768) phase = 32768;
      end
      arg = (phase <= 16384) ? 16384 - phase : phase - 16384;
      r.volume = scaled_volume(vol, arg);
      r.ramp = RAMP_DECAY;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h expected %0h (beat %0d)", what, got, want,
             beats_checked);
    mismatch_count++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [23:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {8'h00, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Wait for the pipeline to empty, then program one setting
  task automatic load_setting(input int s);
    while (pending_gain.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_write(REG_ATTACK_TIME, set_attack[s]);
    apb_write(REG_DECAY_START, set_decay[s]);
    apb_write(REG_ENVELOPE_LENGTH, set_length[s]);
    cur_attack = set_attack[s];
    cur_decay = set_decay[s];
    cur_length = set_length[s];
  endtask

  // Offer one beat, hold until accepted, record its expectation
  task automatic send_beat(input stim_row_t row);
    gain_result_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.play_time = row.play_time;
    in_ch.volume_in = row.volume;
    do @(posedge clk); while (!in_ch.ready);
    if (row.typed) begin
      e.volume = row.typed_volume;
      e.ramp = row.typed_ramp;
      e.fault = row.typed_fault;
    end else begin
      e = predict_gain(row.play_time, row.volume);
    end
    pending_gain.push_back(e);
    beats_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [23:0] random_time();
    longint unsigned span;
    span = cur_length > cur_attack ? cur_length : cur_attack;
    if (cur_decay > span) span = cur_decay;
    span = span + span / 2 + 4;
    if (span > 24'hFFFFFF || $urandom_range(0, 7) == 0) return 24'($urandom);
    return 24'($urandom_range(0, 32'(span)));
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (pressure_req) begin
        out_ch.ready = 1'b0;
        for (int c = 0; c < 300; c++) @(negedge clk);
        pressure_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    gain_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_gain.size() == 0) begin
        report_mismatch("unexpected beat", out_ch.volume_out, 0);
      end else begin
        e = pending_gain.pop_front();
        if (out_ch.volume_out !== e.volume)
          report_mismatch("volume_out", out_ch.volume_out, e.volume);
        if (out_ch.ramp_phase !== e.ramp)
          report_mismatch("ramp_phase", out_ch.ramp_phase, e.ramp);
        if (out_ch.span_fault !== e.fault)
          report_mismatch("span_fault", out_ch.span_fault, e.fault);
      end
      beats_checked++;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int cur_setting;
    in_ch.valid = 1'b0;
    in_ch.play_time = '0;
    in_ch.volume_in = '0;
    for (int i = 0; i <= 1024; i++) cos_table[i] = taylor_cos(i);
    cur_attack = '0;
    cur_decay = '0;
    cur_length = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; setting 0 is the reset state
    cur_setting = 0;
    foreach (directed[i]) begin
      if (directed[i].setting != cur_setting) begin
        cur_setting = directed[i].setting;
        load_setting(cur_setting);
      end
      send_beat(directed[i]);
    end

    // Random beats per setting; last setting runs without idling
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      load_setting(s);
      if (s == 2) pressure_req = 1;
      if (s == NUM_SETTINGS - 1) quiet = 1;
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        row.setting = s;
        row.play_time = random_time();
        row.volume = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                                 : 16'($urandom);
        row.typed = 0;
        send_beat(row);
      end
    end

    while (pending_gain.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d beats over %0d register settings, %0d results checked",
             beats_sent, NUM_SETTINGS, beats_checked);
    $display("Attack, decay, empty-span and past-end ramps under stalls; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_gain.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
